// ===== hw/rtl/sha512_256_hasher_macros.svh =====
// ----------------------------------------------------------------------------
// sha512_256_hasher_macros : assertion helpers
// Short forms for clocked implication checks, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef SHA512_256_HASHER_MACROS_SVH
`define SHA512_256_HASHER_MACROS_SVH

// same-cycle implication
`define S512H_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("s512h check failed");

// next-cycle implication
`define S512H_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("s512h check failed");

`endif

// ===== hw/rtl/s512h_pkg.sv =====
// ----------------------------------------------------------------------------
// s512h_pkg
// Shared types, constants and round functions of the SHA-512/256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package s512h_pkg;

    localparam int ROUNDS          = 80;
    localparam int WORDS_PER_BLOCK = 16;

    localparam logic [6:0]  LAST_ROUND     = 7'(ROUNDS - 1);
    localparam logic [3:0]  LAST_SLOT      = 4'(WORDS_PER_BLOCK - 1);
    localparam logic [3:0]  LEN_HI_SLOT    = 4'(WORDS_PER_BLOCK - 2);
    localparam logic [3:0]  BYTES_PER_WORD = 4'd8;
    localparam logic [7:0]  MARK_BYTE      = 8'b10000000;
    localparam logic [63:0] MARK_WORD      = {MARK_BYTE, 56'h0};

    // SHA-512/256 initial hash value
    localparam logic [63:0] H_INIT [8] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
        64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    // source of a word written to the block buffer
    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_TAIL,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } wsel_t;

    typedef struct packed {
        logic       push;
        wsel_t      wsel;
        logic [3:0] slot;
        logic       bc_en;
        logic [3:0] bc_add;
        logic       load;
        logic       round;
        logic [6:0] kidx;
        logic       update;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    function automatic logic [3:0] sat_count(input logic [3:0] c);
        return (c > BYTES_PER_WORD) ? BYTES_PER_WORD : c;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sigma0(input logic [63:0] x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_sigma1(input logic [63:0] x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] small_sigma0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sigma1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // round constants; indexes past the last round read as zero
    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/s512h_dp.sv =====
// ----------------------------------------------------------------------------
// s512h_dp
// Datapath: block window, round logic, hash state, length count, digest buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module s512h_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire s512h_pkg::dp_cmd_t cmd,
    output s512h_pkg::dp_stat_t     stat,
    input  wire logic [63:0]        s_data,
    input  wire logic [3:0]         s_count,
    output logic [63:0]             m_data,
    output logic                    m_last,
    output logic                    m_valid,
    input  wire logic               m_ready
);
    import s512h_pkg::*;

    logic [63:0] win_reg  [WORDS_PER_BLOCK];   // block buffer / schedule window
    logic [63:0] wv_reg   [8];                 // a..h
    logic [63:0] hash_reg [8];
    logic [63:0] hkw_reg;                      // h + K[t] + W[t], one round ahead
    logic [63:0] bc_reg;                       // message bytes
    logic [63:0] obuf_reg [4];
    logic [1:0]  ocnt_reg;
    logic        ovalid_reg;

    logic [3:0]  cnt;
    logic [63:0] tail_word;
    logic [63:0] push_word;
    logic [63:0] sched_new;
    logic [63:0] t1, t2;
    logic [63:0] hkw_next;

    assign cnt = sat_count(s_count);

    // keep the leading bytes, put the marker byte after them, zero the rest
    always_comb begin
        tail_word = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < cnt) begin
                tail_word[63 - 8 * i -: 8] = s_data[63 - 8 * i -: 8];
            end else if (4'(i) == cnt) begin
                tail_word[63 - 8 * i -: 8] = MARK_BYTE;
            end
        end
    end

    always_comb begin
        case (cmd.wsel)
            SRC_DATA: push_word = s_data;
            SRC_TAIL: push_word = tail_word;
            SRC_MARK: push_word = MARK_WORD;
            SRC_LEN:  push_word = {bc_reg[60:0], 3'b000};
            default:  push_word = '0;
        endcase
    end

    assign sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                     + small_sigma0(win_reg[1]) + win_reg[0];

    assign t1 = hkw_reg + big_sigma1(wv_reg[4])
              + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]));
    assign t2 = big_sigma0(wv_reg[0])
              + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));

    // next round's h is this round's g; its W is the next window tap
    assign hkw_next = cmd.load ? (hash_reg[7] + round_k(cmd.kidx) + win_reg[0])
                               : (wv_reg[6] + round_k(cmd.kidx) + win_reg[1]);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            win_reg[cmd.slot] <= push_word;
        end else if (cmd.round) begin
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WORDS_PER_BLOCK - 1] <= sched_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.round) begin
            hkw_reg <= hkw_next;
        end
        if (cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                wv_reg[i] <= hash_reg[i];
            end
        end else if (cmd.round) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            for (int i = 0; i < 4; i++) begin
                obuf_reg[i] <= hash_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= H_INIT;
            bc_reg     <= '0;
            ocnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.update) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end else if (cmd.finish) begin
                hash_reg <= H_INIT;
            end

            if (cmd.finish) begin
                bc_reg <= '0;
            end else if (cmd.bc_en) begin
                bc_reg <= bc_reg + 64'(cmd.bc_add);
            end

            if (cmd.finish) begin
                ovalid_reg <= 1'b1;
                ocnt_reg   <= '0;
            end else if (ovalid_reg && m_ready) begin
                ocnt_reg <= ocnt_reg + 2'd1;
                if (ocnt_reg == 2'd3) begin
                    ovalid_reg <= 1'b0;
                end
            end
        end
    end

    assign m_data        = obuf_reg[ocnt_reg];
    assign m_last        = (ocnt_reg == 2'd3);
    assign m_valid       = ovalid_reg;
    assign stat.out_busy = ovalid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/s512h_ctrl.sv =====
// ----------------------------------------------------------------------------
// s512h_ctrl
// Controller: word intake, padding sequence, round count and digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module s512h_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_last,
    input  wire logic [3:0]          s_count,
    output logic                     s_ready,
    output s512h_pkg::dp_cmd_t       cmd,
    input  wire s512h_pkg::dp_stat_t stat
);
    import s512h_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MARK   = 7'b0000010,
        ST_PAD    = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] slot_reg, slot_next;
    logic [6:0] rnd_reg, rnd_next;
    logic       mark_reg, mark_next;     // full last word: marker word still due
    logic       pad_reg, pad_next;       // padding under way
    logic       extra_reg, extra_next;   // length does not fit: one more block
    logic       done_reg, done_next;     // length word pushed
    logic [3:0] cnt;

    assign cnt = sat_count(s_count);

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        rnd_next   = rnd_reg;
        mark_next  = mark_reg;
        pad_next   = pad_reg;
        extra_next = extra_reg;
        done_next  = done_reg;
        s_ready    = 1'b0;

        cmd.push   = 1'b0;
        cmd.wsel   = SRC_ZERO;
        cmd.slot   = slot_reg;
        cmd.bc_en  = 1'b0;
        cmd.bc_add = BYTES_PER_WORD;
        cmd.load   = 1'b0;
        cmd.round  = 1'b0;
        cmd.kidx   = rnd_reg + 7'd1;
        cmd.update = 1'b0;
        cmd.finish = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.push  = 1'b1;
                    cmd.bc_en = 1'b1;
                    cmd.wsel  = SRC_DATA;
                    if (s_last) begin
                        cmd.bc_add = cnt;
                        if (cnt == BYTES_PER_WORD) begin
                            mark_next = 1'b1;
                        end else begin
                            cmd.wsel   = SRC_TAIL;
                            pad_next   = 1'b1;
                            extra_next = (slot_reg == LEN_HI_SLOT);
                        end
                    end
                    if (slot_reg == LAST_SLOT) begin
                        state_next = ST_LOAD;
                    end else if (s_last) begin
                        state_next = (cnt == BYTES_PER_WORD) ? ST_MARK : ST_PAD;
                    end
                end
            end
            ST_MARK: begin
                cmd.push   = 1'b1;
                cmd.wsel   = SRC_MARK;
                mark_next  = 1'b0;
                pad_next   = 1'b1;
                extra_next = (slot_reg == LEN_HI_SLOT);
                state_next = (slot_reg == LAST_SLOT) ? ST_LOAD : ST_PAD;
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                cmd.wsel = (slot_reg == LAST_SLOT && !extra_reg) ? SRC_LEN : SRC_ZERO;
                if (slot_reg == LAST_SLOT) begin
                    if (extra_reg) begin
                        extra_next = 1'b0;
                    end else begin
                        done_next = 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cmd.kidx   = '0;
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (rnd_reg == LAST_ROUND) begin
                    rnd_next   = '0;
                    state_next = ST_UPDATE;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (done_reg) begin
                    state_next = ST_FIN;
                end else if (mark_reg) begin
                    state_next = ST_MARK;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b0;
                    pad_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.push) begin
            slot_next = slot_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            rnd_reg   <= '0;
            mark_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            extra_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            rnd_reg   <= rnd_next;
            mark_reg  <= mark_next;
            pad_reg   <= pad_next;
            extra_reg <= extra_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha512_256_hasher.sv =====
// ----------------------------------------------------------------------------
// sha512_256_hasher
// SHA-512/256 digest of a word stream, 256-bit result as four 64-bit words.
// ----------------------------------------------------------------------------
// Message words come in big-endian, first byte in bits 63..56, with a byte
// count in s_tuser and the final word flagged by s_tlast. A word that does
// not close a 16-word block or the message leaves s_tready high for the
// next word. After the word that closes a block, s_tready stays low while
// the working variables are loaded, the single shared round unit runs 80
// rounds and the result is folded into the hash state. After the final
// word the controller appends the 0x80 byte, zero fill and the 128-bit bit
// length at one word per cycle, pausing while a filled block is compressed;
// padding costs one or two such compressions, then the first four hash
// words are copied to the digest buffer and the state restarts. The digest
// drains from that buffer, most significant word first, m_tlast on the
// fourth, while the next message is already being taken; a second digest
// waits only if the buffer is still full. Bit length wraps modulo 2^64.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha512_256_hasher_macros.svh"

module sha512_256_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // message words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] data_word
    input  wire logic [3:0]  s_tuser,   // [3:0] valid_bytes
    input  wire logic        s_tlast,   // last_word
    // digest words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] digest_word
    output logic             m_tlast    // digest_last
);
    import s512h_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: intake, padding, rounds, hand-off
    s512h_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_last  (s_tlast),
        .s_count (s_tuser),
        .s_ready (s_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // window, round unit, hash state, digest buffer
    s512h_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_tdata),
        .s_count (s_tuser),
        .m_data  (m_tdata),
        .m_last  (m_tlast),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

    // digest buffer is never overwritten before it has drained
    `S512H_ASSERT_SAME(a_fin_free, aclk, aresetn, cmd.finish, !stat.out_busy)
    // a load always starts the rounds
    `S512H_ASSERT_NEXT(a_load_round, aclk, aresetn, cmd.load, cmd.round && !s_tready)
    // buffer empties after the fourth digest word
    `S512H_ASSERT_NEXT(a_drain, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule

`default_nettype wire

// ===== bench/sha512_256_hasher_test.sv =====
// ----------------------------------------------------------------------------
// sha512_256_hasher_test
// Self-checking bench for the SHA-512/256 word-stream hasher.
// ----------------------------------------------------------------------------
// A short directed table comes first: the empty message, "abc" with junk
// past the byte count, oversized and zero byte counts, and a message whose
// padding spills into a second block. Random messages of mixed length follow.
// Every word the hasher takes is folded into a local SHA-512/256 model. That
// model queues the four digest words each message should produce, and every
// digest word that leaves the block is compared with the oldest entry. Both
// stream sides idle at random. Once, the digest side is held off for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512_256_hasher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS        = 300;
    localparam int DRAIN_CYCLES        = 400;   // two compressions plus padding, with margin
    localparam int BACKPRESSURE_CYCLES = 1000;
    localparam int HOLD_AFTER_WORDS    = 32;    // digest words seen before the long hold-off
    localparam int REPORT_LIMIT        = 10;

    localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;

    // SHA-512/256 starting chain value
    localparam logic [63:0] CHAIN_IV [8] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
        64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam logic [63:0] SHA_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // published SHA-512/256 digests of the empty string and of "abc"
    localparam logic [255:0] EMPTY_DIGEST =
        256'hc672b8d1ef56ed28_ab87c3622c511406_9bdd3ad7b8f97374_98d0c01ecef0967a;
    localparam logic [255:0] ABC_DIGEST =
        256'h53048e2681941ef9_9b2e29b76b4c7dab_e4c2d0c634fc6d46_e0e2f13107e7af23;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } digest_beat_t;

    typedef struct packed {
        logic         known;
        logic [255:0] digest;
    } known_digest_t;

    typedef struct packed {
        logic [63:0]  data;
        logic [3:0]   nbytes;
        logic         last;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 22;

    // digest typed in only for the two published vectors; the rest go
    // through the local model
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty message: count zero on the only word, data is junk
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, EMPTY_DIGEST},
        // "abc" with junk past the third byte
        '{64'h6162_63DE_ADBE_EF55, 4'd3,  1'b1, 1'b1, ABC_DIGEST},
        // count ignored on a word that is not last; oversized count saturates
        '{64'h0000_0000_0000_0000, 4'd0,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, 256'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd9,  1'b0, 1'b0, 256'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd7,  1'b1, 1'b0, 256'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 4'd1,  1'b1, 1'b0, 256'h0},
        // fifteen words ending with a full one: the marker closes the block, the length needs a second
        '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd0,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd15, 1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd0,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd15, 1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b0, 256'h0},
        '{64'h0000_0000_0000_0000, 4'd8,  1'b0, 1'b0, 256'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 256'h0},
        '{64'h5555_5555_5555_5555, 4'd8,  1'b1, 1'b0, 256'h0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] data_word
    logic [3:0]  s_tuser;   // [3:0] valid_bytes
    logic        s_tlast;   // last_word
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] digest_word
    logic        m_tlast;   // digest_last

    // local SHA-512/256 model state
    logic [63:0] chain [8];
    logic [63:0] blk [16];
    logic [63:0] msg_bytes;
    logic [3:0]  fill;

    digest_beat_t  digest_due [$];      // digest words still to come, oldest first
    known_digest_t known_digests [$];   // one entry per message offered

    int words_offered       = 0;
    int words_taken         = 0;
    int messages_sent       = 0;
    int digest_words_seen   = 0;
    int fail_count          = 0;

    always #5 aclk = ~aclk;

    sha512_256_hasher DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // SHA-512/256 model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        logic [127:0] both;
        both = {x, x} >> n;
        return both[63:0];
    endfunction

    // 80 rounds over blk[], folded into the chain value
    function automatic void fold_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] s0, s1, t1, t2;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = blk[t];
        for (t = 16; t < 80; t++) begin
            s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
            s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (t = 0; t < 8; t++)
            v[t] = chain[t];
        for (t = 0; t < 80; t++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++)
            chain[t] = chain[t] + v[t];
    endfunction

    function automatic void put_block_word(input logic [63:0] w);
        blk[fill] = w;
        fill = fill + 4'd1;
        if (fill == 4'd0)
            fold_block();
    endfunction

    function automatic void restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain[i] = CHAIN_IV[i];
        msg_bytes = '0;
        fill      = '0;
    endfunction

    // takes one message word; returns 1 with the digest when the message closes
    function automatic bit absorb_word(input logic [63:0] data, input logic [3:0] nb,
                                       input logic last, output logic [255:0] dg);
        logic [3:0]  n;
        logic [63:0] keep;
        logic [63:0] mark;
        int          nbits;
        dg = '0;
        if (!last) begin
            msg_bytes = msg_bytes + 64'd8;
            put_block_word(data);
            return 1'b0;
        end
        n = (nb > 4'd8) ? 4'd8 : nb;
        nbits = 8 * int'(n);
        msg_bytes = msg_bytes + 64'(n);
        if (n == 4'd8) begin
            put_block_word(data);
            put_block_word(PAD_MARK);
        end else begin
            // bytes past the count read as zero, marker byte right after them
            keep = (n == 4'd0) ? 64'h0 : (~64'h0 << (64 - nbits));
            mark = 64'h80 << (56 - nbits);
            put_block_word((data & keep) | mark);
        end
        // no room left for the length in this block: pad out and start another
        if (fill > 4'd14)
            put_block_word(64'h0);
        while (fill < 4'd14)
            put_block_word(64'h0);
        put_block_word(64'h0);
        put_block_word(msg_bytes << 3);
        dg = {chain[0], chain[1], chain[2], chain[3]};
        restart_message();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Word and digest monitor: input side first, then output side
    // ------------------------------------------------------------------------
    function automatic void report_mismatch(input string what, input digest_beat_t got,
                                            input digest_beat_t want);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t ns: %s: got word %h last %b, expected word %h last %b",
                     $time, what, got.word, got.last, want.word, want.last);
    endfunction

    always @(posedge aclk) begin
        logic [255:0]  dg;
        known_digest_t entry;
        digest_beat_t  got;
        digest_beat_t  want;
        int            k;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                words_taken++;
                if (absorb_word(s_tdata, s_tuser, s_tlast, dg)) begin
                    entry = known_digests.pop_front();
                    if (entry.known)
                        dg = entry.digest;
                    for (k = 0; k < 4; k++)
                        digest_due.push_back(digest_beat_t'{word: dg[255 - 64*k -: 64],
                                                            last: (k == 3)});
                end
            end
            if (m_tvalid && m_tready) begin
                got = digest_beat_t'{word: m_tdata, last: m_tlast};
                digest_words_seen++;
                if (digest_due.size() == 0) begin
                    report_mismatch("digest word with none expected", got, '0);
                end else begin
                    want = digest_due.pop_front();
                    if (got.word !== want.word)
                        report_mismatch("digest word differs", got, want);
                    else if (got.last !== want.last)
                        report_mismatch("last flag differs", got, want);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Idle gaps: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Digest side: random tready, calm stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial begin : digest_sink
        int  hold;
        int  cyc;
        bit  calm;
        bit  squeezed;
        hold     = 0;
        cyc      = 0;
        calm     = 1'b0;
        squeezed = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 200 == 0)
                calm = ($urandom_range(0, 2) == 0);
            // hold the digest side off while the sender keeps offering, so the
            // digest buffer fills and the block stops taking words
            if (!squeezed && digest_words_seen >= HOLD_AFTER_WORDS) begin
                squeezed = 1'b1;
                hold     = BACKPRESSURE_CYCLES;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if (!calm)
                    hold = idle_length();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Message side
    // ------------------------------------------------------------------------
    task automatic offer_word(input logic [63:0] d, input logic [3:0] nb, input logic last,
                              input bit calm, input known_digest_t known);
        int gap;
        gap = calm ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (last)
            known_digests.push_back(known);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= nb;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_offered++;
        if (last)
            messages_sent++;
    endtask

    task automatic send_random_message();
        int          len;
        int          r;
        int          i;
        bit          calm;
        logic [63:0] d;
        logic [3:0]  nb;
        r = $urandom_range(0, 99);
        if (r < 60)
            len = $urandom_range(1, 8);
        else if (r < 75)
            len = $urandom_range(14, 17);   // padding around the block edge
        else if (r < 90)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 40);
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                d = 64'h0;
            else if (r == 1)
                d = ~64'h0;
            else
                d = {$urandom, $urandom};
            if (i != len - 1)
                nb = 4'($urandom);
            else if ($urandom_range(0, 9) < 7)
                nb = 4'($urandom_range(0, 8));
            else
                nb = 4'($urandom_range(9, 15));
            offer_word(d, nb, (i == len - 1), calm, '0);
        end
    endtask

    initial begin : stimulus
        int i;
        restart_message();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            offer_word(DIRECTED[i].data, DIRECTED[i].nbytes, DIRECTED[i].last, 1'b0,
                       known_digest_t'{known: DIRECTED[i].known, digest: DIRECTED[i].digest});

        while (words_offered - DIRECTED_ROWS < RANDOM_WORDS)
            send_random_message();
        s_tvalid <= 1'b0;

        // wait for every word to be taken and every digest word to arrive
        while (words_taken != words_offered || digest_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages from %0d words (%0d from the directed table),",
                 messages_sent, words_offered, DIRECTED_ROWS);
        $display("checked %0d digest words through a %0d-cycle output hold-off; %0d failures",
                 digest_words_seen, BACKPRESSURE_CYCLES, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin : watchdog
        #(8_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/s512h_pkg.sv
hw/rtl/s512h_dp.sv
hw/rtl/s512h_ctrl.sv
hw/rtl/sha512_256_hasher.sv
bench/sha512_256_hasher_test.sv
